FILE: sv/hsl2rgb_pkg.sv
// Shared types and constants for the HSL to RGB converter.
package hsl2rgb_pkg;

   // Piece of the hue ramp that a channel's offset hue falls in
   typedef enum logic [1:0] {
      SEG_RISE = 2'd0,
      SEG_HIGH = 2'd1,
      SEG_FALL = 2'd2,
      SEG_LOW  = 2'd3
   } seg_type;

   // Channel lanes
   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;
   localparam int unsigned NUM_CH   = 3;

endpackage

FILE: sv/hsl_to_rgb_converter.sv
// Pipelined HSL to 8-bit RGB pixel converter.
//
// Usage:
//   Present a pixel on req_hue, req_saturation and req_lightness with start
//   high; it is taken at the rising edge where start is high and busy is low.
//   busy is always low, so one beat can be taken on every clock cycle.
//   Hue is a fraction of a turn (2^FRAC_BITS = one turn); saturation and
//   lightness carry FRAC_BITS fraction bits, so 2^FRAC_BITS means 1.0.
//   The result appears on rsp_red, rsp_green and rsp_blue for one cycle,
//   marked by rsp_valid, once the beat has passed the register stages below.
//   Throughput is one pixel per cycle; latency is set by the four register
//   stages: offsets and s*m product, per-channel ramp product, ramp sum,
//   and byte scaling with saturation to 0..255.
//   Results must be taken in the cycle they are shown; the receiver has no
//   way to stall the pipeline.
//   Synchronous reset clears the valid bits of every stage, so beats in
//   flight at reset are dropped; the data path is not reset.
module hsl_to_rgb_converter #(
   parameter int unsigned FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FRAC_BITS-1:0] req_hue,
   input  logic [FRAC_BITS:0]   req_saturation,
   input  logic [FRAC_BITS:0]   req_lightness,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue
);

   localparam int unsigned F   = FRAC_BITS;
   localparam int unsigned TW  = F + 2;       // offset hue, units of 1/(3*ONE) turn
   localparam int unsigned SW  = F + 2;       // signed saturation / lightness terms
   localparam int unsigned QW  = 2 * F + 4;   // q, p and s*m, units of 2^-(2F)
   localparam int unsigned VW  = 3 * F + 5;   // ramp value, units of 2^-(3F)
   localparam int unsigned NCH = hsl2rgb_pkg::NUM_CH;

   localparam logic [TW-1:0] T_HALF   = TW'(1) << (F - 1);
   localparam logic [TW-1:0] T_ONE    = TW'(1) << F;
   localparam logic [TW-1:0] T_3HALF  = TW'(3) << (F - 1);
   localparam logic [TW-1:0] T_TWO    = TW'(2) << F;
   localparam logic [TW-1:0] T_THREE  = TW'(3) << F;
   localparam logic signed [SW-1:0] S_ONE = SW'(1) << F;

   // Stage A registers
   logic                        valid_a_ff;
   logic signed [QW-1:0]        sm_a_ff, sm_a_in;
   logic [F:0]                  l_a_ff;
   logic [NCH-1:0][TW-1:0]      t_a_ff, t_a_in;

   // Stage B registers
   logic                        valid_b_ff;
   logic signed [QW-1:0]        q2_b_ff, q2_b_in;
   logic signed [QW-1:0]        p2_b_ff, p2_b_in;
   logic [NCH-1:0][VW-1:0]      prod_b_ff, prod_b_in;
   hsl2rgb_pkg::seg_type        seg_b_ff [NCH];
   hsl2rgb_pkg::seg_type        seg_b_in [NCH];

   // Stage C registers
   logic                        valid_c_ff;
   logic [NCH-1:0][VW-1:0]      v_c_ff, v_c_in;

   // Stage D registers
   logic                        valid_d_ff;
   logic [NCH-1:0][7:0]         byte_d_ff, byte_d_in;

   logic                        accept;
   logic signed [SW-1:0]        s_ext;
   logic signed [SW-1:0]        l_ext;
   logic signed [SW-1:0]        m_sel;
   logic [TW-1:0]               t_green;
   logic [TW-1:0]               t_red_raw;
   logic signed [QW-1:0]        l_one;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage A: form s*m and the three offset hues
   always_comb begin
      s_ext = SW'(signed'({1'b0, req_saturation}));
      l_ext = SW'(signed'({1'b0, req_lightness}));
      // below one half q uses l*(1+s), else l + s*(1-l)
      if (req_lightness[F:F-1] == 2'b00) begin
         m_sel = l_ext;
      end else begin
         m_sel = S_ONE - l_ext;
      end
      sm_a_in = QW'(s_ext * m_sel);

      t_green   = {2'b00, req_hue} + {1'b0, req_hue, 1'b0};
      t_red_raw = t_green + T_ONE;
      if (t_red_raw >= T_THREE) begin
         t_a_in[hsl2rgb_pkg::CH_RED] = t_red_raw - T_THREE;
      end else begin
         t_a_in[hsl2rgb_pkg::CH_RED] = t_red_raw;
      end
      t_a_in[hsl2rgb_pkg::CH_GREEN] = t_green;
      if (t_green >= T_ONE) begin
         t_a_in[hsl2rgb_pkg::CH_BLUE] = t_green - T_ONE;
      end else begin
         t_a_in[hsl2rgb_pkg::CH_BLUE] = t_green + T_TWO;
      end
   end

   // Stage B: q and p, segment pick and slope product per channel
   always_comb begin
      logic [F-1:0] u;
      l_one   = QW'(signed'({1'b0, l_a_ff, {F{1'b0}}}));
      q2_b_in = l_one + sm_a_ff;
      p2_b_in = l_one - sm_a_ff;
      for (int c = 0; c < NCH; c++) begin
         priority if (t_a_ff[c] < T_HALF) begin
            seg_b_in[c] = hsl2rgb_pkg::SEG_RISE;
            u           = t_a_ff[c][F-1:0];
         end else if (t_a_ff[c] < T_3HALF) begin
            seg_b_in[c] = hsl2rgb_pkg::SEG_HIGH;
            u           = '0;
         end else if (t_a_ff[c] < T_TWO) begin
            seg_b_in[c] = hsl2rgb_pkg::SEG_FALL;
            u           = F'(T_TWO - t_a_ff[c]);
         end else begin
            seg_b_in[c] = hsl2rgb_pkg::SEG_LOW;
            u           = '0;
         end
         prod_b_in[c] = VW'(sm_a_ff * signed'({1'b0, u}));
      end
   end

   // Stage C: sum the ramp value in units of 2^-(3F)
   always_comb begin
      logic signed [VW-1:0] q_sc;
      logic signed [VW-1:0] p_sc;
      logic signed [VW-1:0] slope;
      q_sc = {q2_b_ff[QW-1], q2_b_ff, {F{1'b0}}};
      p_sc = {p2_b_ff[QW-1], p2_b_ff, {F{1'b0}}};
      for (int c = 0; c < NCH; c++) begin
         slope = {prod_b_ff[c][VW-3:0], 2'b00};
         unique case (seg_b_ff[c])
            hsl2rgb_pkg::SEG_RISE,
            hsl2rgb_pkg::SEG_FALL: v_c_in[c] = p_sc + slope;
            hsl2rgb_pkg::SEG_HIGH: v_c_in[c] = q_sc;
            hsl2rgb_pkg::SEG_LOW:  v_c_in[c] = p_sc;
            default:               v_c_in[c] = p_sc;
         endcase
      end
   end

   // Stage D: scale by 255, truncate and clamp to a byte
   always_comb begin
      logic [3*F+7:0] scaled;
      for (int c = 0; c < NCH; c++) begin
         scaled = {v_c_ff[c][3*F-1:0], 8'h00} - {8'h00, v_c_ff[c][3*F-1:0]};
         priority if (v_c_ff[c][VW-1] || (v_c_ff[c] == '0)) begin
            byte_d_in[c] = 8'h00;
         end else if (v_c_ff[c][VW-2:3*F] != '0) begin
            byte_d_in[c] = 8'hFF;
         end else begin
            byte_d_in[c] = scaled[3*F+7:3*F];
         end
      end
   end

   // Advance valid bits; drop beats in flight on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         valid_a_ff <= accept;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
      end
   end

   // Advance the data path
   always_ff @(posedge clock) begin
      sm_a_ff   <= sm_a_in;
      l_a_ff    <= req_lightness;
      t_a_ff    <= t_a_in;
      q2_b_ff   <= q2_b_in;
      p2_b_ff   <= p2_b_in;
      prod_b_ff <= prod_b_in;
      seg_b_ff  <= seg_b_in;
      v_c_ff    <= v_c_in;
      byte_d_ff <= byte_d_in;
   end

   assign rsp_valid = valid_d_ff;
   assign rsp_red   = byte_d_ff[hsl2rgb_pkg::CH_RED];
   assign rsp_green = byte_d_ff[hsl2rgb_pkg::CH_GREEN];
   assign rsp_blue  = byte_d_ff[hsl2rgb_pkg::CH_BLUE];

   // Every beat taken comes out on rsp_valid after the four register stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted beat did not emerge after four cycles");

   // No result without a matching beat taken earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("result strobe without matching beat");

   // Zero saturation gives grey
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_saturation == '0)) |->
         ##4 ((rsp_red == rsp_green) && (rsp_green == rsp_blue)))
      else $error("zero saturation did not give equal channels");

   // Zero lightness gives black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_lightness == '0)) |->
         ##4 ((rsp_red == 8'h00) && (rsp_green == 8'h00) && (rsp_blue == 8'h00)))
      else $error("zero lightness did not give black");

endmodule
